[rtl/hdu_pkg.sv]
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants for the HID descriptor usage finder: item and
// result payloads, parser state, status codes and item header encodings.
// ----------------------------------------------------------------------------
package hdu_pkg;

   localparam logic [7:0] HDR_TAG_MASK     = 8'hFC;
   localparam logic [3:0] LONG_PREFIX      = 4'hF;
   localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
   localparam logic [7:0] TAG_USAGE        = 8'h08;
   localparam logic [1:0] SIZE_CODE_FOUR   = 2'd3;
   localparam logic [2:0] LEN_FOUR         = 3'd4;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PAGE  = 2'd1,
      PEND_USAGE = 2'd2
   } pend_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] page_value;
      logic [15:0] usage_value;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  bytes_left;
      logic [2:0]  item_length;
      pend_type    pending_tag;
      logic [15:0] collect_value;
      logic [15:0] page_hold;
      logic [15:0] usage_hold;
      logic [1:0]  found_flags;
      logic        finished;
   } state_type;

   localparam state_type STATE_RESET = '{
      bytes_left:    3'd0,
      item_length:   3'd0,
      pending_tag:   PEND_NONE,
      collect_value: 16'd0,
      page_hold:     16'd0,
      usage_hold:    16'd0,
      found_flags:   2'b00,
      finished:      1'b0
   };

endpackage

[rtl/hid_descriptor_usage_finder.sv]
// ----------------------------------------------------------------------------
// hid_descriptor_usage_finder
// Scans a HID report descriptor for its Usage Page and Usage items.
// ----------------------------------------------------------------------------
// Descriptor bytes arrive on the req_ channel, one byte per transfer, with
// req_data.last marking the final byte. Each descriptor produces exactly one
// item on the rsp_ channel: success with both values as soon as both items
// are settled, an error on a long item prefix, or not-found at the end.
// Bytes after a result are consumed without effect until the final byte.
// An accepted byte is registered in the input register, then stepped through
// the parser into the result register once no result is stalled there.
// One byte is taken every cycle while no result is stalled; the limit
// is the single parser step between the input and result registers.
// When rsp_ready is low with a result waiting, the input register still
// takes one byte, then req_ready falls until the result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a descriptor.
// ----------------------------------------------------------------------------
module hid_descriptor_usage_finder
   import hdu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type in_ff;
   logic    in_valid_ff;
   logic    in_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    advance;
   logic    emit;
   rsp_type result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   hdu_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_valid_ff)
      else $error("parser result did not reach the result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("parser stepped while a result was stalled");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result item changed while stalled");

endmodule

[rtl/hdu_parser.sv]
// ----------------------------------------------------------------------------
// hdu_parser
// Walks the short items of a report descriptor one byte per step, holds the
// parser state and flags the single result of each descriptor.
// ----------------------------------------------------------------------------
module hdu_parser
   import hdu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    emit,
   output rsp_type result
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_type  nxt;
      logic [2:0] len;
      logic [2:0] k;
      logic [2:0] left_dec;
      logic       settle;
      logic [15:0] settle_val;
      status_type status;

      nxt        = state_ff;
      len        = 3'd0;
      k          = state_ff.item_length - state_ff.bytes_left;
      left_dec   = state_ff.bytes_left - 3'd1;
      settle     = 1'b0;
      settle_val = 16'd0;
      status     = ST_FOUND;
      emit       = 1'b0;

      if (!state_ff.finished) begin
         if (state_ff.bytes_left == 3'd0) begin
            if (item.data_byte[7:4] == LONG_PREFIX) begin
               emit         = 1'b1;
               status       = ST_INVALID;
               nxt.finished = 1'b1;
            end else begin
               len = (item.data_byte[1:0] == SIZE_CODE_FOUR) ? LEN_FOUR
                                                             : {1'b0, item.data_byte[1:0]};
               nxt.pending_tag = PEND_NONE;
               if ((item.data_byte & HDR_TAG_MASK) == TAG_USAGE_PAGE) begin
                  nxt.found_flags[0] = 1'b1;
                  nxt.pending_tag    = PEND_PAGE;
               end else if ((item.data_byte & HDR_TAG_MASK) == TAG_USAGE) begin
                  nxt.found_flags[1] = 1'b1;
                  nxt.pending_tag    = PEND_USAGE;
               end
               // Empty, four-byte and truncated items settle to zero at once.
               settle            = (len == 3'd0) || (len == LEN_FOUR) || item.last;
               nxt.bytes_left    = len;
               nxt.item_length   = len;
               nxt.collect_value = 16'd0;
            end
         end else begin
            if (state_ff.pending_tag != PEND_NONE) begin
               if (k == 3'd0) begin
                  nxt.collect_value[7:0] = state_ff.collect_value[7:0] | item.data_byte;
               end else if (k == 3'd1) begin
                  nxt.collect_value[15:8] = state_ff.collect_value[15:8] | item.data_byte;
               end
            end
            nxt.bytes_left = left_dec;
            if (left_dec == 3'd0) begin
               settle     = 1'b1;
               settle_val = nxt.collect_value;
            end else if (item.last) begin
               settle = 1'b1;
            end
         end

         if (settle) begin
            if (nxt.pending_tag == PEND_PAGE) begin
               nxt.page_hold = settle_val;
            end else if (nxt.pending_tag == PEND_USAGE) begin
               nxt.usage_hold = settle_val;
            end
            nxt.pending_tag = PEND_NONE;
         end

         if (!nxt.finished) begin
            if ((nxt.found_flags == 2'b11) && (nxt.pending_tag == PEND_NONE)) begin
               emit         = 1'b1;
               status       = ST_FOUND;
               nxt.finished = 1'b1;
            end else if (item.last) begin
               emit         = 1'b1;
               status       = ST_NOT_FOUND;
               nxt.finished = 1'b1;
            end
         end
      end

      result.status      = status;
      result.page_value  = nxt.page_hold;
      result.usage_value = nxt.usage_hold;

      // The final byte always starts the next descriptor afresh.
      state_in = item.last ? STATE_RESET : nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   a_no_emit_when_finished: assert property (@(posedge clock) disable iff (reset)
      step && state_ff.finished |-> !emit)
      else $error("result raised after the descriptor's result was given");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> state_ff == STATE_RESET)
      else $error("parser state not cleared after the final byte");

   a_emit_marks_finished: assert property (@(posedge clock) disable iff (reset)
      step && emit && !item.last |=> state_ff.finished)
      else $error("finished flag not set after a result");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_left <= state_ff.item_length && state_ff.item_length <= LEN_FOUR)
      else $error("item byte counters out of range");

endmodule
